>>> src/ishr_pkg.sv
// Types, constants and codes shared by the sample history ring files.
`timescale 1ns / 1ps

package ishr_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int ACT_W     = 3;
  localparam int STAT_W    = 2;
  localparam int TIME_W    = 32;
  localparam int VAL_W     = 48;
  localparam int IDX_W     = 10;
  localparam int CNT_OUT_W = 11;
  localparam int ALU_W     = 50;
  localparam int RAM_W     = VAL_W + TIME_W;

  localparam logic [TIME_W-1:0] PUSH_INTERVAL_RST = TIME_W'(5000);

  typedef enum logic [ACT_W-1:0] {
    ACT_START = 3'd0,
    ACT_TICK  = 3'd1,
    ACT_READ  = 3'd2,
    ACT_STATS = 3'd3,
    ACT_CLEAR = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_NOT_STARTED = 2'd1,
    STAT_RANGE       = 2'd2
  } status_e;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [TIME_W-1:0] time_now;
    logic [VAL_W-1:0]  sample_value;
    logic [IDX_W-1:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic                 pushed;
    logic [VAL_W-1:0]     entry_value;
    logic [TIME_W-1:0]    entry_time;
    logic [CNT_OUT_W-1:0] history_count;
    logic [TIME_W-1:0]    latest_time;
    logic [VAL_W-1:0]     min_value;
    logic [VAL_W-1:0]     max_value;
    logic [VAL_W-1:0]     baseline_value;
    logic [VAL_W-1:0]     current_value;
  } rsp_t;

endpackage

>>> src/ishr_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
`timescale 1ns / 1ps

interface ishr_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

>>> src/interval_sampled_history_ring.sv
// Sample history ring: interval-gated recording with entry read and min/max stats.
//
// Requests arrive as beats on req_i (start, tick, read entry, stats, clear);
// every request yields exactly one beat on rsp_o. The user must set push_interval
// through cfg_we_i / cfg_wdata_i only while idle; the block does not enforce this.
// One request is in work at a time; req_i.ready is high while the sequencer
// is idle. Steps between accept and the finish step:
//   start, clear, unknown code : none (also tick before start, read out of range)
//   tick                       : three passes through the shared subtractor
//   read entry                 : one registered RAM read
//   stats                      : min and max over the ring sharing one
//                                subtractor, a min step then a max step per entry
// The next request can be taken in the same cycle that the result turns valid.
// The result sits in an output register, so a new request is accepted while
// the previous result waits; a stalled receiver holds rsp_o and the next
// result waits in the sequencer until the output register frees.
// Reset empties the history, clears start state and loads push_interval with
// 5000. The ring RAM needs no clearing pass: only live entries are read.
`timescale 1ns / 1ps

module interval_sampled_history_ring #(
  parameter int DEPTH = ishr_pkg::DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ishr_pkg::TIME_W-1:0] cfg_wdata_i,
  ishr_stream_if.sink                 req_i,
  ishr_stream_if.source               rsp_o
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int XW     = (CW > ishr_pkg::IDX_W) ? CW : ishr_pkg::IDX_W;
  localparam int TIME_W = ishr_pkg::TIME_W;
  localparam int VAL_W  = ishr_pkg::VAL_W;
  localparam int ALU_W  = ishr_pkg::ALU_W;
  localparam int RAM_W  = ishr_pkg::RAM_W;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_TICK_REL = 8'b0000_0010,
    S_TICK_DIF = 8'b0000_0100,
    S_TICK_CMP = 8'b0000_1000,
    S_RD_DATA  = 8'b0001_0000,
    S_SCAN_LO  = 8'b0010_0000,
    S_SCAN_HI  = 8'b0100_0000,
    S_FIN      = 8'b1000_0000
  } state_e;

  state_e              state_q, state_d;
  ishr_pkg::req_t      item_q, item_d;
  ishr_pkg::rsp_t      res_q, res_d;
  ishr_pkg::rsp_t      out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic [TIME_W-1:0]   push_interval_q;
  logic                started_q, started_d;
  logic [TIME_W-1:0]   start_time_q, start_time_d;
  logic [TIME_W-1:0]   last_push_q, last_push_d;
  logic [VAL_W-1:0]    baseline_q, baseline_d;
  logic [VAL_W-1:0]    current_q, current_d;
  logic [AW-1:0]       head_q, head_d;
  logic [AW-1:0]       oldest_q, oldest_d;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic [CW-1:0]       left_q, left_d;
  logic [TIME_W-1:0]   rel_q, rel_d;
  logic [ALU_W-1:0]    acc_q, acc_d;
  logic [VAL_W-1:0]    lo_q, lo_d;
  logic [VAL_W-1:0]    hi_q, hi_d;

  logic [ALU_W-1:0]    alu_a, alu_b, alu_diff;
  logic                alu_neg;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [RAM_W-1:0]    ram_wdata, ram_rdata;
  logic [VAL_W-1:0]    rd_val;
  logic [TIME_W-1:0]   rd_time;

  logic                accept, out_free, idx_ok;
  logic [AW:0]         slot_sum;
  logic [AW-1:0]       slot;
  ishr_pkg::req_t      req;

  assign req      = req_i.payload;
  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign idx_ok   = XW'(req.entry_index) < XW'(count_q);
  assign slot_sum = {1'b0, oldest_q} + {1'b0, AW'(req.entry_index)};
  assign slot     = (slot_sum >= (AW+1)'(DEPTH)) ? AW'(slot_sum - (AW+1)'(DEPTH))
                                                 : AW'(slot_sum);
  assign rd_val   = ram_rdata[RAM_W-1:TIME_W];
  assign rd_time  = ram_rdata[TIME_W-1:0];

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  // shared subtractor
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_q)
      S_TICK_REL: begin
        alu_a = ALU_W'(item_q.time_now);
        alu_b = ALU_W'(start_time_q);
      end
      S_TICK_DIF: begin
        alu_a = acc_q;
        alu_b = ALU_W'(last_push_q);
      end
      S_TICK_CMP: begin
        alu_a = acc_q;
        alu_b = ALU_W'(push_interval_q);
      end
      S_SCAN_LO: begin
        alu_a = ALU_W'(rd_val);
        alu_b = ALU_W'(lo_q);
      end
      S_SCAN_HI: begin
        alu_a = ALU_W'(hi_q);
        alu_b = ALU_W'(rd_val);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign alu_diff = alu_a - alu_b;
  assign alu_neg  = alu_diff[ALU_W-1];

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    res_d        = res_q;
    started_d    = started_q;
    start_time_d = start_time_q;
    last_push_d  = last_push_q;
    baseline_d   = baseline_q;
    current_d    = current_q;
    head_d       = head_q;
    oldest_d     = oldest_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    left_d       = left_q;
    rel_d        = rel_q;
    acc_d        = acc_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = ptr_q;
    ram_wdata    = {item_q.sample_value, rel_q};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d  = req;
          res_d   = '0;
          state_d = S_FIN;
          unique case (req.action)
            ishr_pkg::ACT_START: begin
              if (!started_q) begin
                start_time_d = req.time_now;
                last_push_d  = '0;
                baseline_d   = req.sample_value;
                current_d    = req.sample_value;
                started_d    = 1'b1;
              end
            end
            ishr_pkg::ACT_TICK: begin
              if (!started_q) begin
                res_d.status = ishr_pkg::STAT_NOT_STARTED;
              end else begin
                current_d = req.sample_value;
                state_d   = S_TICK_REL;
              end
            end
            ishr_pkg::ACT_READ: begin
              if (idx_ok) begin
                ram_re    = 1'b1;
                ram_raddr = slot;
                state_d   = S_RD_DATA;
              end else begin
                res_d.status = ishr_pkg::STAT_RANGE;
              end
            end
            ishr_pkg::ACT_STATS: begin
              res_d.history_count  = ishr_pkg::CNT_OUT_W'(count_q);
              res_d.baseline_value = baseline_q;
              res_d.current_value  = current_q;
              if (count_q != '0) begin
                res_d.latest_time = last_push_q;
                ram_re    = 1'b1;
                ram_raddr = oldest_q;
                ptr_d     = (oldest_q == AW'(DEPTH - 1)) ? '0 : oldest_q + 1'b1;
                left_d    = count_q;
                lo_d      = '1;
                hi_d      = '0;
                state_d   = S_SCAN_LO;
              end
            end
            ishr_pkg::ACT_CLEAR: begin
              started_d    = 1'b0;
              start_time_d = '0;
              last_push_d  = '0;
              baseline_d   = '0;
              current_d    = '0;
              head_d       = '0;
              oldest_d     = '0;
              count_d      = '0;
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_TICK_REL: begin
        acc_d   = alu_diff;
        rel_d   = alu_diff[TIME_W-1:0];
        state_d = S_TICK_DIF;
      end
      S_TICK_DIF: begin
        acc_d   = alu_diff;
        state_d = S_TICK_CMP;
      end
      S_TICK_CMP: begin
        if (!alu_neg) begin
          ram_we = 1'b1;
          head_d = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
          if (count_q == CW'(DEPTH)) begin
            oldest_d = (oldest_q == AW'(DEPTH - 1)) ? '0 : oldest_q + 1'b1;
          end else begin
            count_d = count_q + 1'b1;
          end
          last_push_d  = rel_q;
          res_d.pushed = 1'b1;
        end
        state_d = S_FIN;
      end
      S_RD_DATA: begin
        res_d.entry_value = rd_val;
        res_d.entry_time  = rd_time;
        state_d           = S_FIN;
      end
      S_SCAN_LO: begin
        if (alu_neg) begin
          lo_d = rd_val;
        end
        state_d = S_SCAN_HI;
      end
      S_SCAN_HI: begin
        if (alu_neg) begin
          hi_d = rd_val;
        end
        if (left_q == CW'(1)) begin
          res_d.min_value = lo_q;
          res_d.max_value = alu_neg ? rd_val : hi_q;
          state_d         = S_FIN;
        end else begin
          ram_re  = 1'b1;
          ptr_d   = (ptr_q == AW'(DEPTH - 1)) ? '0 : ptr_q + 1'b1;
          left_d  = left_q - 1'b1;
          state_d = S_SCAN_LO;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_d       = out_q;
    if (state_q == S_FIN && out_free) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      out_valid_q     <= 1'b0;
      push_interval_q <= ishr_pkg::PUSH_INTERVAL_RST;
      started_q       <= 1'b0;
      start_time_q    <= '0;
      last_push_q     <= '0;
      baseline_q      <= '0;
      current_q       <= '0;
      head_q          <= '0;
      oldest_q        <= '0;
      count_q         <= '0;
      ptr_q           <= '0;
      left_q          <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        push_interval_q <= cfg_wdata_i;
      end
      started_q    <= started_d;
      start_time_q <= start_time_d;
      last_push_q  <= last_push_d;
      baseline_q   <= baseline_d;
      current_q    <= current_d;
      head_q       <= head_d;
      oldest_q     <= oldest_d;
      count_q      <= count_d;
      ptr_q        <= ptr_d;
      left_q       <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
    rel_q  <= rel_d;
    acc_q  <= acc_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
  end

  ishr_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("history count exceeds ring depth");

  a_fill_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != CW'(DEPTH)) |-> (oldest_q == '0 && CW'(head_q) == count_q))
    else $error("ring pointers out of step with count before wrap");

  a_push_effect : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TICK_CMP && ram_we) |=>
      (count_q != '0 && last_push_q == $past(rel_q)))
    else $error("push did not update count or last push time");

  a_out_from_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result beat raised outside the finish step");
`endif

endmodule

>>> src/ishr_ram.sv
// Simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module ishr_ram #(
  parameter int WIDTH = ishr_pkg::RAM_W,
  parameter int DEPTH = ishr_pkg::DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
